/* rtl/core/wsdf_pkg.sv */
// ----------------------------------------------------------------------------
// wsdf_pkg
// Types and constants shared by the WebSocket frame deframer modules.
// ----------------------------------------------------------------------------
package wsdf_pkg;

    localparam int unsigned LIMIT_W  = 17;
    localparam int unsigned LEN_W    = 64;
    localparam int unsigned KEY_W    = 32;
    localparam int unsigned HDR_W    = 4;
    localparam int unsigned LBL_W    = 4;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 17'd8192;

    localparam logic [6:0]       LEN16_CODE = 7'd126;
    localparam logic [6:0]       LEN64_CODE = 7'd127;
    localparam logic [HDR_W-1:0] HDR_BASE   = 4'd2;
    localparam logic [HDR_W-1:0] HDR_KEY    = 4'd4;
    localparam logic [HDR_W-1:0] HDR_LEN16  = 4'd2;
    localparam logic [HDR_W-1:0] HDR_LEN64  = 4'd8;
    localparam logic [LBL_W-1:0] LBL_LEN16  = 4'd2;
    localparam logic [LBL_W-1:0] LBL_LEN64  = 4'd8;

    localparam logic ACT_BYTE    = 1'b0;
    localparam logic ACT_RESTART = 1'b1;

    typedef enum logic [5:0] {
        PH_HEAD0   = 6'b000001,
        PH_HEAD1   = 6'b000010,
        PH_EXTLEN  = 6'b000100,
        PH_MASK    = 6'b001000,
        PH_PAYLOAD = 6'b010000,
        PH_SKIP    = 6'b100000
    } wsdf_phase_t;

    typedef struct packed {
        logic       action;
        logic [7:0] data_byte;
    } wsdf_in_t;

    typedef struct packed {
        logic [3:0] frame_opcode;
        logic [7:0] payload_byte;
        logic       byte_valid;
        logic       frame_end;
    } wsdf_out_t;

    typedef struct packed {
        logic     en;
        wsdf_in_t item;
    } wsdf_step_t;

    typedef struct packed {
        logic      valid;
        wsdf_out_t data;
    } wsdf_res_t;

endpackage

/* rtl/core/websocket_frame_deframer_core.sv */
// ----------------------------------------------------------------------------
// websocket_frame_deframer_core
// Streaming WebSocket frame parser: one received byte in, at most one
// unmasked payload byte out, oversized frames skipped whole.
//
//   channel | direction | payload    | handshake
//   --------+-----------+------------+----------------------
//   in      | input     | wsdf_in_t  | in_valid / in_stall
//   out     | output    | wsdf_out_t | out_valid / out_stall
//   cfg     | input     | frame_limit| cfg_we / cfg_data
//
// One byte per cycle sustained while the output is not stalled; a transfer
// passes the input register, then the result register after the parser logic.
// Reset clears the parser, both stage valids and sets the limit to 8192.
// A stalled result holds the input register; the input stalls only then.
// ----------------------------------------------------------------------------
module websocket_frame_deframer_core
    import wsdf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  wsdf_in_t           in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output wsdf_out_t          out_data,
    input  logic               cfg_we,
    input  logic [LIMIT_W-1:0] cfg_data
);

    logic [LIMIT_W-1:0] limit_reg;
    logic               in_vld_reg, in_vld_next;
    wsdf_in_t           in_data_reg;
    logic               out_vld_reg, out_vld_next;
    wsdf_out_t          out_data_reg;
    logic               adv;
    logic               take;
    wsdf_step_t         step;
    wsdf_res_t          res;

    assign adv       = in_vld_reg && (!out_vld_reg || !out_stall);
    assign in_stall  = in_vld_reg && !adv;
    assign take      = in_valid && !in_stall;
    assign step.en   = adv;
    assign step.item = in_data_reg;
    assign out_valid = out_vld_reg;
    assign out_data  = out_data_reg;

    wsdf_parser u_parser
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame_limit (limit_reg),
        .step        (step),
        .res         (res)
    );

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (take)
        begin
            in_vld_next = 1'b1;
        end
        else if (adv)
        begin
            in_vld_next = 1'b0;
        end

        out_vld_next = out_vld_reg;
        if (adv)
        begin
            out_vld_next = res.valid;
        end
        else if (out_vld_reg && !out_stall)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg   <= LIMIT_RESET;
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                limit_reg <= cfg_data;
            end
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_data_reg <= in_data;
        end
        if (adv && res.valid)
        begin
            out_data_reg <= res.data;
        end
    end

`ifndef SYNTH
    a_stall_needs_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall && in_vld_reg))
        else $error("input stalled without a held result");

    a_empty_is_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_data.byte_valid) |-> out_data.frame_end)
        else $error("empty result not marked as frame end");

    a_held_item_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (in_vld_reg && !out_valid) |=> (!in_vld_reg || $past(take)))
        else $error("input item not advanced into free result stage");
`endif

endmodule

/* rtl/core/wsdf_parser.sv */
// ----------------------------------------------------------------------------
// wsdf_parser
// Frame header state machine, length check and payload unmasking; takes one
// byte per step and gives at most one result in the same cycle.
// ----------------------------------------------------------------------------
module wsdf_parser
    import wsdf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [LIMIT_W-1:0] frame_limit,
    input  wsdf_step_t         step,
    output wsdf_res_t          res
);

    wsdf_phase_t       phase_reg, phase_next;
    logic [3:0]        opcode_reg, opcode_next;
    logic              mask_reg, mask_next;
    logic [LBL_W-1:0]  lbl_reg, lbl_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [1:0]        kpos_reg, kpos_next;
    logic              drop_reg, drop_next;
    logic [HDR_W-1:0]  hdr_reg, hdr_next;

    always_comb
    begin
        logic [7:0]       b;
        logic [HDR_W-1:0] hs;
        logic [LEN_W-1:0] len_new;
        logic [LBL_W-1:0] lbl_dec;
        logic [LEN_W-1:0] rem_dec;
        logic [LIMIT_W:0] total;
        logic             len_done;
        logic             body_go;
        logic             body_drop;
        logic [LEN_W-1:0] body_len;
        logic [7:0]       key_byte;

        b          = step.item.data_byte;
        hs         = hdr_reg;
        len_new    = len_reg;
        lbl_dec    = lbl_reg - 1'b1;
        rem_dec    = len_reg - 1'b1;
        len_done   = 1'b0;
        body_go    = 1'b0;
        body_drop  = drop_reg;
        body_len   = len_reg;
        key_byte   = key_reg[KEY_W-1 -: 8];
        total      = '0;

        phase_next  = phase_reg;
        opcode_next = opcode_reg;
        mask_next   = mask_reg;
        lbl_next    = lbl_reg;
        len_next    = len_reg;
        key_next    = key_reg;
        kpos_next   = kpos_reg;
        drop_next   = drop_reg;
        hdr_next    = hdr_reg;
        res         = '0;
        res.data.frame_opcode = opcode_reg;

        unique case (kpos_reg)
            2'd0: key_byte = key_reg[31:24];
            2'd1: key_byte = key_reg[23:16];
            2'd2: key_byte = key_reg[15:8];
            2'd3: key_byte = key_reg[7:0];
            default: key_byte = key_reg[31:24];
        endcase

        if (step.en)
        begin
            if (step.item.action == ACT_RESTART)
            begin
                phase_next  = PH_HEAD0;
                opcode_next = '0;
                mask_next   = 1'b0;
                lbl_next    = '0;
                len_next    = '0;
                key_next    = '0;
                kpos_next   = '0;
                drop_next   = 1'b0;
                hdr_next    = '0;
            end
            else
            begin
                unique case (phase_reg)
                    PH_HEAD1:
                    begin
                        mask_next = b[7];
                        hs        = HDR_BASE + (b[7] ? HDR_KEY : '0);
                        len_new   = '0;
                        if (b[6:0] == LEN16_CODE)
                        begin
                            hs         = hs + HDR_LEN16;
                            lbl_next   = LBL_LEN16;
                            phase_next = PH_EXTLEN;
                        end
                        else if (b[6:0] == LEN64_CODE)
                        begin
                            hs         = hs + HDR_LEN64;
                            lbl_next   = LBL_LEN64;
                            phase_next = PH_EXTLEN;
                        end
                        else
                        begin
                            len_new  = {{(LEN_W-7){1'b0}}, b[6:0]};
                            len_done = 1'b1;
                        end
                        hdr_next = hs;
                        len_next = len_new;
                    end
                    PH_EXTLEN:
                    begin
                        len_new  = {len_reg[LEN_W-9:0], b};
                        len_next = len_new;
                        lbl_next = lbl_dec;
                        len_done = (lbl_dec == '0);
                    end
                    PH_MASK:
                    begin
                        key_next  = {key_reg[KEY_W-9:0], b};
                        kpos_next = kpos_reg + 1'b1;
                        body_go   = (kpos_reg == 2'd3);
                    end
                    PH_PAYLOAD:
                    begin
                        kpos_next = kpos_reg + 1'b1;
                        len_next  = rem_dec;
                        res.valid = 1'b1;
                        res.data.payload_byte = b ^ (mask_reg ? key_byte : 8'h00);
                        res.data.byte_valid   = 1'b1;
                        if (rem_dec == '0)
                        begin
                            res.data.frame_end = 1'b1;
                            phase_next         = PH_HEAD0;
                        end
                    end
                    PH_SKIP:
                    begin
                        len_next = rem_dec;
                        if (rem_dec == '0)
                        begin
                            drop_next  = 1'b0;
                            phase_next = PH_HEAD0;
                        end
                    end
                    default:
                    begin
                        opcode_next = b[3:0];
                        mask_next   = 1'b0;
                        drop_next   = 1'b0;
                        phase_next  = PH_HEAD1;
                    end
                endcase

                if (len_done)
                begin
                    total = {1'b0, len_new[LIMIT_W-1:0]} + {{(LIMIT_W+1-HDR_W){1'b0}}, hs};
                    body_drop = (len_new[LEN_W-1:LIMIT_W] != '0)
                              || (total > {1'b0, frame_limit});
                    drop_next = body_drop;
                    body_len  = len_new;
                    if (mask_next)
                    begin
                        key_next   = '0;
                        kpos_next  = '0;
                        phase_next = PH_MASK;
                    end
                    else
                    begin
                        body_go = 1'b1;
                    end
                end

                if (body_go)
                begin
                    kpos_next = '0;
                    len_next  = body_len;
                    if (body_len == '0)
                    begin
                        phase_next = PH_HEAD0;
                        if (body_drop)
                        begin
                            drop_next = 1'b0;
                        end
                        else
                        begin
                            res.valid          = 1'b1;
                            res.data.frame_end = 1'b1;
                        end
                    end
                    else
                    begin
                        phase_next = body_drop ? PH_SKIP : PH_PAYLOAD;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEAD0;
            opcode_reg <= '0;
            mask_reg   <= 1'b0;
            lbl_reg    <= '0;
            len_reg    <= '0;
            key_reg    <= '0;
            kpos_reg   <= '0;
            drop_reg   <= 1'b0;
            hdr_reg    <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            opcode_reg <= opcode_next;
            mask_reg   <= mask_next;
            lbl_reg    <= lbl_next;
            len_reg    <= len_next;
            key_reg    <= key_next;
            kpos_reg   <= kpos_next;
            drop_reg   <= drop_next;
            hdr_reg    <= hdr_next;
        end
    end

endmodule
